// ===== rtl/core/eau_pkg.sv =====
// Shared types, codes and constants of the elementwise activation unit.
// Holds the exponent table, rounding and saturation helpers.
// Depends on nothing; the divider, the unit and the testbench import it.
package eau_pkg;

  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_SIGMOID = 3'd1;
  localparam logic [2:0] KIND_RELU    = 3'd2;
  localparam logic [2:0] KIND_ELU     = 3'd3;
  localparam logic [2:0] KIND_SELU    = 3'd4;
  localparam logic [2:0] KIND_TANH    = 3'd5;
  localparam logic [2:0] KIND_SWISH   = 3'd6;

  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_BWD = 1'b1;

  localparam logic [1:0] CFG_KIND  = 2'd0;
  localparam logic [1:0] CFG_DIR   = 2'd1;
  localparam logic [1:0] CFG_ALPHA = 2'd2;

  localparam int LOG2E_Q8        = 369;
  localparam int SELU_LAMBDA_Q16 = 68859;
  localparam int SELU_LA_Q16     = 115221;
  localparam int ONE_Q16         = 65536;
  localparam int ALPHA_RESET     = 256;

  localparam int NUM_W = 49;
  localparam int DEN_W = 24;
  localparam int QUO_W = 17;

  typedef enum logic [2:0] {
    CLS_DIRECT   = 3'd0,
    CLS_SIGMOID  = 3'd1,
    CLS_TANH     = 3'd2,
    CLS_SWISH_FW = 3'd3,
    CLS_SWISH_BW = 3'd4,
    CLS_ELU_NEG  = 3'd5,
    CLS_SELU_NEG = 3'd6,
    CLS_SELU_POS = 3'd7
  } res_cls_t;

  typedef struct packed {
    res_cls_t          cls;
    logic signed [15:0] res;
    logic signed [15:0] x;
    logic              qneg;
    logic              last;
  } eau_side_t;

  function automatic logic [16:0] pow2_neg(input logic [4:0] k);
    logic [16:0] v;
    unique case (k)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      5'd16: v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // shift right, round half away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int s);
    logic signed [63:0] half;
    half = 64'sd1 <<< (s - 1);
    if (v[63]) begin
      return -((-v + half) >>> s);
    end
    return (v + half) >>> s;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    priority if (v > 64'sd32767) begin
      return 16'sh7fff;
    end else if (v < -64'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

// ===== rtl/core/eau_if.sv =====
// Request channels of the elementwise activation unit: element in, result out.
// Valid/ready handshake; no dependencies.
interface eau_elem_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pre_activation;
  logic signed [15:0] post_activation;
  logic signed [15:0] upstream_grad;
  logic               last_element;

  modport source(output valid, pre_activation, post_activation, upstream_grad,
                 last_element, input ready);
  modport sink(input valid, pre_activation, post_activation, upstream_grad,
               last_element, output ready);
endinterface

interface eau_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] result_value;
  logic               result_last;

  modport source(output valid, result_value, result_last, input ready);
  modport sink(input valid, result_value, result_last, output ready);
endinterface

// ===== rtl/core/eau_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Flags quotients that do not fit QUO_W bits. Depends on eau_pkg.
module eau_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [eau_pkg::NUM_W-1:0] in_num,
  input  logic [eau_pkg::DEN_W-1:0] in_den,
  input  eau_pkg::eau_side_t        in_side,
  output logic                      out_valid,
  output logic [eau_pkg::QUO_W-1:0] out_quo,
  output logic                      out_ovf,
  output eau_pkg::eau_side_t        out_side
);
  import eau_pkg::*;

  logic             vld  [QUO_W];
  logic [NUM_W-1:0] rem  [QUO_W];
  logic [DEN_W-1:0] den  [QUO_W];
  logic [QUO_W-1:0] quo  [QUO_W];
  logic             ovf  [QUO_W];
  eau_side_t        side [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [NUM_W-1:0] shd;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic             ovf_in;
    logic             vld_in;
    eau_side_t        side_in;
    logic             take;

    if (j == 0) begin : g_first
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign quo_in  = '0;
      assign ovf_in  = in_num >= (NUM_W'(in_den) << QUO_W);
      assign vld_in  = in_valid;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem[j-1];
      assign den_in  = den[j-1];
      assign quo_in  = quo[j-1];
      assign ovf_in  = ovf[j-1];
      assign vld_in  = vld[j-1];
      assign side_in = side[j-1];
    end

    assign shd  = NUM_W'(den_in) << (QUO_W - 1 - j);
    assign take = rem_in >= shd;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (adv) begin
        vld[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[j]  <= take ? rem_in - shd : rem_in;
        quo[j]  <= {quo_in[QUO_W-2:0], take};
        den[j]  <= den_in;
        ovf[j]  <= ovf_in;
        side[j] <= side_in;
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign out_quo   = quo[QUO_W-1];
  assign out_ovf   = ovf[QUO_W-1];
  assign out_side  = side[QUO_W-1];

endmodule

// ===== rtl/core/elementwise_activation_unit.sv =====
// Elementwise activation unit: forward activation or backward gradient, Q8.8.
// One element per cycle while the result is not stalled.
// The 17-stage divider and the multiplier stages set the depth.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
// Synchronous reset clears valid bits and loads kind none, forward, alpha 1.0.
// Depends on eau_pkg, eau_if and eau_div.
module elementwise_activation_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [14:0] cfg_data,
  eau_elem_if.sink   element,
  eau_res_if.source  result
);
  import eau_pkg::*;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] g;
    logic               last;
    logic [2:0]         kind;
    logic               dir;
  } item_t;

  logic [2:0]  kind;
  logic        dir;
  logic [14:0] alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind  <= KIND_NONE;
      dir   <= DIR_FWD;
      alpha <= 15'(ALPHA_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KIND:  kind  <= cfg_data[2:0];
        CFG_DIR:   dir   <= cfg_data[0];
        CFG_ALPHA: alpha <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv = !result.valid || result.ready;
  assign element.ready = adv;

  // stage 1: exponent argument, first gradient product
  item_t              it0;
  logic [15:0]        mag0;
  logic [16:0]        texp0;
  logic signed [16:0] opa;
  logic signed [24:0] opb;

  assign it0 = '{x: element.pre_activation, y: element.post_activation,
                 g: element.upstream_grad, last: element.last_element,
                 kind: kind, dir: dir};
  assign mag0  = it0.x[15] ? 16'(-it0.x) : 16'(it0.x);
  assign texp0 = (kind == KIND_TANH) ? {mag0, 1'b0} : {1'b0, mag0};

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (kind)
      KIND_SIGMOID: begin
        opa = 17'(it0.y);
        opb = 25'sd256 - 25'(it0.y);
      end
      KIND_TANH: begin
        opa = 17'(it0.y);
        opb = 25'(it0.y);
      end
      KIND_ELU: begin
        opa = 17'(it0.g);
        opb = 25'(it0.y) + 25'($signed({1'b0, alpha}));
      end
      KIND_SELU: begin
        opa = 17'(it0.g);
        opb = it0.y[15] ? (25'(it0.y) <<< 8) + 25'(SELU_LA_Q16) : 25'(SELU_LAMBDA_Q16);
      end
      KIND_SWISH: begin
        opa = 17'(it0.g);
        opb = 25'(it0.y);
      end
      default: ;
    endcase
  end

  logic               s1_vld;
  item_t              s1_it;
  logic [24:0]        s1_lp;
  logic signed [41:0] s1_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= element.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_it <= it0;
      s1_lp <= 25'(texp0) * 25'(LOG2E_Q8);
      s1_m1 <= 42'(opa) * 42'(opb);
    end
  end

  // stage 2: table interpolation, second gradient product
  logic [16:0]        u1;
  logic [16:0]        ta1;
  logic [16:0]        tb1;
  logic [20:0]        dr1;
  logic signed [33:0] a1;
  logic signed [17:0] b1;
  logic signed [51:0] p1n;

  assign u1  = s1_lp[24:8];
  assign ta1 = pow2_neg({1'b0, u1[7:4]});
  assign tb1 = pow2_neg({1'b0, u1[7:4]} + 5'd1);
  assign dr1 = 21'(ta1 - tb1) * 21'(u1[3:0]);

  always_comb begin
    a1 = '0;
    b1 = '0;
    unique case (s1_it.kind)
      KIND_SIGMOID: begin
        a1 = 34'(s1_m1);
        b1 = 18'(s1_it.g);
      end
      KIND_TANH: begin
        a1 = 34'(ONE_Q16) - 34'(s1_m1);
        b1 = 18'(s1_it.g);
      end
      KIND_SWISH: begin
        a1 = 34'(s1_m1);
        b1 = 18'(s1_it.x) - 18'(s1_it.y) + 18'sd256;
      end
      default: ;
    endcase
    if (s1_it.kind == KIND_ELU || s1_it.kind == KIND_SELU) begin
      p1n = 52'(s1_m1);
    end else begin
      p1n = 52'(a1) * 52'(b1);
    end
  end

  logic               s2_vld;
  item_t              s2_it;
  logic [16:0]        s2_m;
  logic [8:0]         s2_ip;
  logic signed [51:0] s2_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_it <= s1_it;
      s2_m  <= ta1 - 17'(dr1 >> 4);
      s2_ip <= u1[16:8];
      s2_p  <= p1n;
    end
  end

  // stage 3: exponential, divider operands, rounded gradients
  logic [16:0]        e2;
  logic [16:0]        ome2;
  logic [17:0]        d2;
  logic [NUM_W-1:0]   sig_num2;
  logic [NUM_W-1:0]   tanh_num2;
  logic [51:0]        pabs2;
  logic [15:0]        aabs2;
  res_cls_t           cls2;
  logic signed [15:0] res2;
  logic [NUM_W-1:0]   num2;
  logic [DEN_W-1:0]   den2;
  logic [16:0]        mua2;
  logic [16:0]        mub2;
  logic               qneg2;

  assign e2        = (s2_ip >= 9'd17) ? 17'd0 : (s2_m >> s2_ip[4:0]);
  assign ome2      = 17'(ONE_Q16) - e2;
  assign d2        = 18'(ONE_Q16) + 18'(e2);
  assign sig_num2  = NUM_W'(64'h1_0000_0000) + NUM_W'(d2 >> 1);
  assign tanh_num2 = (NUM_W'(ome2) << 16) + NUM_W'(d2 >> 1);
  assign pabs2     = s2_p[51] ? 52'(-s2_p) : 52'(s2_p);
  assign aabs2     = s2_it.x[15] ? 16'(-s2_it.x) : 16'(s2_it.x);

  always_comb begin
    cls2  = CLS_DIRECT;
    res2  = s2_it.x;
    num2  = '0;
    den2  = '0;
    mua2  = '0;
    mub2  = '0;
    qneg2 = 1'b0;
    if (s2_it.dir == DIR_FWD) begin
      unique case (s2_it.kind)
        KIND_RELU: res2 = s2_it.x[15] ? 16'sd0 : s2_it.x;
        KIND_SIGMOID: begin
          cls2 = CLS_SIGMOID;
          num2 = sig_num2;
          den2 = DEN_W'(d2);
        end
        KIND_TANH: begin
          cls2 = CLS_TANH;
          num2 = tanh_num2;
          den2 = DEN_W'(d2);
        end
        KIND_SWISH: begin
          cls2 = CLS_SWISH_FW;
          num2 = sig_num2;
          den2 = DEN_W'(d2);
        end
        KIND_ELU: begin
          if (s2_it.x[15]) begin
            cls2 = CLS_ELU_NEG;
            mua2 = {2'b00, alpha};
            mub2 = ome2;
          end
        end
        KIND_SELU: begin
          if (s2_it.x[15]) begin
            cls2 = CLS_SELU_NEG;
            mua2 = 17'(SELU_LA_Q16);
            mub2 = ome2;
          end else begin
            cls2 = CLS_SELU_POS;
            mua2 = {2'b00, s2_it.x[14:0]};
            mub2 = 17'(SELU_LAMBDA_Q16);
          end
        end
        default: ;
      endcase
    end else begin
      res2 = s2_it.g;
      unique case (s2_it.kind)
        KIND_SIGMOID, KIND_TANH, KIND_SELU: res2 = sat16(rnd_shr(64'(s2_p), 16));
        KIND_RELU: res2 = (!s2_it.y[15] && s2_it.y != 16'sd0) ? s2_it.g : 16'sd0;
        KIND_ELU: begin
          if (s2_it.y[15]) begin
            res2 = sat16(rnd_shr(64'(s2_p), 8));
          end
        end
        KIND_SWISH: begin
          if (s2_it.x == 16'sd0) begin
            res2 = sat16(rnd_shr(64'(s2_it.g), 1));
          end else begin
            cls2  = CLS_SWISH_BW;
            num2  = NUM_W'(pabs2) + (NUM_W'(aabs2) << 7);
            den2  = DEN_W'(aabs2) << 8;
            qneg2 = s2_p[51] ^ s2_it.x[15];
          end
        end
        default: ;
      endcase
    end
  end

  logic               s3_vld;
  res_cls_t           s3_cls;
  logic signed [15:0] s3_res;
  logic [NUM_W-1:0]   s3_num;
  logic [DEN_W-1:0]   s3_den;
  logic [33:0]        s3_mul;
  logic signed [15:0] s3_x;
  logic               s3_qneg;
  logic               s3_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_cls  <= cls2;
      s3_res  <= res2;
      s3_num  <= num2;
      s3_den  <= den2;
      s3_mul  <= 34'(mua2) * 34'(mub2);
      s3_x    <= s2_it.x;
      s3_qneg <= qneg2;
      s3_last <= s2_it.last;
    end
  end

  // stage 4: round the elu and selu products, load the divider
  eau_side_t side3;
  logic signed [63:0] mul3;

  assign mul3 = $signed(64'(s3_mul));

  always_comb begin
    side3 = '{cls: s3_cls, res: s3_res, x: s3_x, qneg: s3_qneg, last: s3_last};
    unique case (s3_cls)
      CLS_ELU_NEG: begin
        side3.cls = CLS_DIRECT;
        side3.res = sat16(rnd_shr(-mul3, 16));
      end
      CLS_SELU_NEG: begin
        side3.cls = CLS_DIRECT;
        side3.res = sat16(rnd_shr(-mul3, 24));
      end
      CLS_SELU_POS: begin
        side3.cls = CLS_DIRECT;
        side3.res = sat16(rnd_shr(mul3, 16));
      end
      default: ;
    endcase
  end

  logic             s4_vld;
  eau_side_t        s4_side;
  logic [NUM_W-1:0] s4_num;
  logic [DEN_W-1:0] s4_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (adv) begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_side <= side3;
      s4_num  <= s3_num;
      s4_den  <= s3_den;
    end
  end

  logic             dv_valid;
  logic [QUO_W-1:0] dv_quo;
  logic             dv_ovf;
  eau_side_t        dv_side;

  eau_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s4_vld),
    .in_num    (s4_num),
    .in_den    (s4_den),
    .in_side   (s4_side),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_ovf   (dv_ovf),
    .out_side  (dv_side)
  );

  // post stage 1: finish sigmoid, tanh, swish gradient; swish product
  logic [16:0]        sig5;
  logic [16:0]        tq5;
  logic signed [15:0] res5;

  assign sig5 = dv_side.x[15] ? 17'(ONE_Q16) - dv_quo : dv_quo;
  assign tq5  = (dv_quo + 17'd128) >> 8;

  always_comb begin
    unique case (dv_side.cls)
      CLS_SIGMOID: res5 = 16'((sig5 + 17'd128) >> 8);
      CLS_TANH:    res5 = dv_side.x[15] ? -16'(tq5) : 16'(tq5);
      CLS_SWISH_BW: begin
        if (dv_ovf) begin
          res5 = dv_side.qneg ? 16'sh8000 : 16'sh7fff;
        end else begin
          res5 = sat16(dv_side.qneg ? -$signed(64'(dv_quo)) : $signed(64'(dv_quo)));
        end
      end
      default: res5 = dv_side.res;
    endcase
  end

  logic               p1_vld;
  logic               p1_swf;
  logic signed [15:0] p1_res;
  logic signed [33:0] p1_mul;
  logic               p1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else if (adv) begin
      p1_vld <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_swf  <= (dv_side.cls == CLS_SWISH_FW);
      p1_res  <= res5;
      p1_mul  <= 34'(dv_side.x) * 34'($signed({1'b0, sig5}));
      p1_last <= dv_side.last;
    end
  end

  // output register
  logic               p2_vld;
  logic signed [15:0] p2_res;
  logic               p2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else if (adv) begin
      p2_vld <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_res  <= p1_swf ? sat16(rnd_shr(64'(p1_mul), 16)) : p1_res;
      p2_last <= p1_last;
    end
  end

  assign result.valid        = p2_vld;
  assign result.result_value = p2_res;
  assign result.result_last  = p2_last;

`ifndef ASSERT_OFF
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !element.ready)
    else $error("element request taken while result stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    element.valid && element.ready |=> s1_vld)
    else $error("accepted element missing from first stage");

  a_div_to_post: assert property (@(posedge clk) disable iff (rst)
    adv |=> p1_vld == $past(dv_valid))
    else $error("divider output lost or duplicated");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> p1_vld == $past(p1_vld) && s4_vld == $past(s4_vld))
    else $error("pipeline moved during stall");
`endif

endmodule

// ===== dv/elementwise_activation_unit_test.sv =====
// Testbench of elementwise_activation_unit: directed table, then random phases per setting.
// Expected results: known table values, else an in-bench Q8.8 activation/gradient predictor.
// Depends on eau_pkg, eau_if and elementwise_activation_unit (rtl/core).
`timescale 1ns / 1ps

module elementwise_activation_unit_test;
  import eau_pkg::*;

  localparam int LATENCY = 23;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 52;
  localparam logic [2:0] KIND_SPARE = 3'd7;
  localparam logic [1:0] CFG_SPARE  = 2'd3;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] g;
    logic               last;
  } elem_t;

  typedef struct {
    logic signed [15:0] value;
    logic               last;
  } outcome_t;

  typedef struct {
    logic [2:0]         kind;
    logic               dir;
    logic [14:0]        alpha;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] g;
    logic               last;
    bit                 known;
    logic signed [15:0] value;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_data;

  eau_elem_if element();
  eau_res_if  result();

  elementwise_activation_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .element(element.sink), .result(result.source)
  );

  always #6 clk = ~clk;

  logic [2:0]  cur_kind;
  logic        cur_dir;
  logic [14:0] cur_alpha;
  outcome_t    pending_results[$];
  int          errors = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_settings = 0;
  bit          rx_random = 1'b0;
  bit          gaps_on = 1'b0;
  longint      exp_tab[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                               46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint exp_neg_q16(longint t);
    longint u, ip, f, k, r, m;
    u = (t * LOG2E_Q8) >>> 8;
    ip = u >>> 8;
    f = u & 255;
    k = f >>> 4;
    r = f & 15;
    m = exp_tab[k] - (((exp_tab[k] - exp_tab[k + 1]) * r) >>> 4);
    if (ip >= 17) return 0;
    return m >>> ip;
  endfunction

  function automatic longint sigmoid_q16(longint x);
    longint d, s;
    d = ONE_Q16 + exp_neg_q16(x < 0 ? -x : x);
    s = ((64'sd1 <<< 32) + d / 2) / d;
    return x < 0 ? ONE_Q16 - s : s;
  endfunction

  function automatic logic signed [15:0] predict_activation(elem_t e);
    longint x, y, g, r, em1, ev, den, num, t;
    x = e.x;
    y = e.y;
    g = e.g;
    if (cur_dir == DIR_FWD) begin
      case (cur_kind)
        KIND_SIGMOID: r = round_div(sigmoid_q16(x), 256);
        KIND_RELU: r = x < 0 ? 0 : x;
        KIND_ELU: begin
          em1 = exp_neg_q16(-x) - ONE_Q16;
          r = x >= 0 ? x : round_div(longint'(cur_alpha) * em1, 65536);
        end
        KIND_SELU: begin
          em1 = exp_neg_q16(-x) - ONE_Q16;
          r = x >= 0 ? round_div(x * SELU_LAMBDA_Q16, 65536)
                     : round_div(SELU_LA_Q16 * em1, 64'sd1 <<< 24);
        end
        KIND_TANH: begin
          ev = exp_neg_q16(2 * (x < 0 ? -x : x));
          den = ONE_Q16 + ev;
          t = round_div((((ONE_Q16 - ev) * ONE_Q16) + den / 2) / den, 256);
          r = x < 0 ? -t : t;
        end
        KIND_SWISH: r = round_div(x * sigmoid_q16(x), 65536);
        default: r = x;
      endcase
    end else begin
      case (cur_kind)
        KIND_SIGMOID: r = round_div(g * y * (256 - y), 65536);
        KIND_RELU: r = y > 0 ? g : 0;
        KIND_ELU: r = y >= 0 ? g : round_div(g * (y + longint'(cur_alpha)), 256);
        KIND_SELU: r = y >= 0 ? round_div(g * SELU_LAMBDA_Q16, 65536)
                              : round_div(g * (y * 256 + SELU_LA_Q16), 65536);
        KIND_TANH: r = round_div(g * (ONE_Q16 - y * y), 65536);
        KIND_SWISH: begin
          if (x == 0) begin
            r = round_div(g, 2);
          end else begin
            num = g * y * (x - y + 256);
            den = x * 256;
            if (den < 0) begin
              den = -den;
              num = -num;
            end
            r = round_div(num, den);
          end
        end
        default: r = g;
      endcase
    end
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [14:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_KIND: cur_kind = data[2:0];
      CFG_DIR: cur_dir = data[0];
      CFG_ALPHA: cur_alpha = data;
      default: ;
    endcase
  endtask

  task automatic drain();
    element.valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic apply_setting(logic [2:0] kind, logic dir, logic [14:0] alpha);
    if (kind == cur_kind && dir == cur_dir && alpha == cur_alpha) return;
    drain();
    write_reg(CFG_KIND, {12'($urandom_range(0, 4095)), kind});
    write_reg(CFG_DIR, {14'($urandom_range(0, 16383)), dir});
    write_reg(CFG_ALPHA, alpha);
    write_reg(CFG_SPARE, 15'($urandom_range(0, 32767)));
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic offer(elem_t e, bit known, logic signed [15:0] value);
    outcome_t o;
    element.valid <= 1'b1;
    element.pre_activation <= e.x;
    element.post_activation <= e.y;
    element.upstream_grad <= e.g;
    element.last_element <= e.last;
    do @(posedge clk); while (!element.ready);
    o.value = known ? value : predict_activation(e);
    o.last = e.last;
    pending_results.push_back(o);
    n_sent++;
  endtask

  function automatic logic signed [15:0] pick16(logic [2:0] kind, bit post);
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($signed($urandom_range(0, 3072)) - 1536);
      2: return 16'($signed($urandom_range(0, 32)) - 16);
      3: begin
        case ($urandom_range(0, 4))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return 16'sd0;
          3: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      default: begin
        if (post && kind == KIND_SIGMOID) return 16'($urandom_range(0, 256));
        if (post && kind == KIND_TANH) return 16'($signed($urandom_range(0, 512)) - 256);
        return 16'($signed($urandom_range(0, 1024)) - 512);
      end
    endcase
  endfunction

  // directed table and random phases
  initial begin
    dir_row_t rows[20];
    elem_t e;
    int burst;
    rows = '{
      '{KIND_NONE,    DIR_FWD, 15'd256,   -16'sd32768, 16'sd0, 16'sd0, 1'b0, 1, -16'sd32768},
      '{KIND_NONE,    DIR_FWD, 15'd256,   16'sd32767, 16'sd0, 16'sd0, 1'b1, 1, 16'sd32767},
      '{KIND_RELU,    DIR_FWD, 15'd256,   -16'sd5, 16'sd9, 16'sd9, 1'b0, 1, 16'sd0},
      '{KIND_RELU,    DIR_FWD, 15'd256,   16'sd32767, 16'sd0, 16'sd0, 1'b1, 1, 16'sd32767},
      '{KIND_SIGMOID, DIR_FWD, 15'd256,   16'sd0, 16'sd0, 16'sd0, 1'b0, 1, 16'sd128},
      '{KIND_SIGMOID, DIR_FWD, 15'd256,   -16'sd32768, 16'sd0, 16'sd0, 1'b0, 0, 16'sd0},
      '{KIND_TANH,    DIR_FWD, 15'd256,   16'sd0, 16'sd0, 16'sd0, 1'b0, 1, 16'sd0},
      '{KIND_TANH,    DIR_FWD, 15'd256,   -16'sd300, 16'sd0, 16'sd0, 1'b1, 0, 16'sd0},
      '{KIND_ELU,     DIR_FWD, 15'd0,     -16'sd700, 16'sd0, 16'sd0, 1'b0, 0, 16'sd0},
      '{KIND_ELU,     DIR_FWD, 15'd32767, -16'sd32768, 16'sd0, 16'sd0, 1'b0, 0, 16'sd0},
      '{KIND_ELU,     DIR_FWD, 15'd32767, 16'sd100, 16'sd0, 16'sd0, 1'b0, 1, 16'sd100},
      '{KIND_SELU,    DIR_FWD, 15'd256,   16'sd32767, 16'sd0, 16'sd0, 1'b0, 1, 16'sd32767},
      '{KIND_SELU,    DIR_FWD, 15'd256,   -16'sd400, 16'sd0, 16'sd0, 1'b0, 0, 16'sd0},
      '{KIND_SWISH,   DIR_FWD, 15'd256,   16'sd32767, 16'sd0, 16'sd0, 1'b0, 0, 16'sd0},
      '{KIND_SPARE,   DIR_FWD, 15'd256,   16'sd77, 16'sd5, 16'sd5, 1'b1, 1, 16'sd77},
      '{KIND_SPARE,   DIR_BWD, 15'd256,   16'sd3, 16'sd5, -16'sd1234, 1'b0, 1, -16'sd1234},
      '{KIND_RELU,    DIR_BWD, 15'd256,   16'sd3, 16'sd0, 16'sd500, 1'b0, 1, 16'sd0},
      '{KIND_SIGMOID, DIR_BWD, 15'd256,   16'sd0, -16'sd32768, 16'sd32767, 1'b0, 1, -16'sd32768},
      '{KIND_SWISH,   DIR_BWD, 15'd256,   16'sd0, 16'sd40, 16'sd3, 1'b1, 1, 16'sd2},
      '{KIND_SWISH,   DIR_BWD, 15'd256,   -16'sd32768, 16'sd32767, -16'sd32768, 1'b0, 0, 16'sd0}
    };
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= 2'd0;
    cfg_data <= 15'd0;
    element.valid <= 1'b0;
    element.pre_activation <= 16'sd0;
    element.post_activation <= 16'sd0;
    element.upstream_grad <= 16'sd0;
    element.last_element <= 1'b0;
    cur_kind = KIND_NONE;
    cur_dir = DIR_FWD;
    cur_alpha = 15'(ALPHA_RESET);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      apply_setting(rows[i].kind, rows[i].dir, rows[i].alpha);
      e = '{rows[i].x, rows[i].y, rows[i].g, rows[i].last};
      offer(e, rows[i].known, rows[i].value);
    end

    for (int p = 0; p < 18; p++) begin
      logic [14:0] alpha;
      alpha = p == 16 ? 15'd0 : p == 17 ? 15'd32767 : 15'($urandom_range(0, 32767));
      if (p < 16) apply_setting(3'(p / 2), p[0], alpha);
      else apply_setting(KIND_ELU, p[0], alpha);
      rx_random <= p % 3 != 0;
      gaps_on = p % 4 != 1;
      burst = $urandom_range(1, 20);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        e.x = pick16(cur_kind, 0);
        e.y = pick16(cur_kind, 1);
        e.g = pick16(cur_kind, 0);
        e.last = $urandom_range(0, 7) == 0;
        offer(e, 0, 16'sd0);
        if (gaps_on && --burst == 0) begin
          element.valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
          burst = $urandom_range(1, 20);
        end
      end
    end

    element.valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    $display("Sent %0d elements (%0d from the table) across %0d register settings;",
             n_sent, $size(rows), n_settings);
    $display("checked %0d results, every kind in both directions plus kind 7.", n_checked);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result side: check, then pick ready
  initial begin
    int hold_cnt;
    bit hold_done;
    outcome_t o;
    hold_cnt = 0;
    hold_done = 0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result.valid && result.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: result_value %0d result_last %0b",
                 result.result_value, result.result_last);
          errors++;
        end else begin
          o = pending_results.pop_front();
          if (result.result_value !== o.value) begin
            $error("result_value: expected %0d, actual %0d", o.value, result.result_value);
            errors++;
          end
          if (result.result_last !== o.last) begin
            $error("result_last: expected %0b, actual %0b", o.last, result.result_last);
            errors++;
          end
          n_checked++;
        end
      end
      if (!hold_done && n_checked == 250) begin
        hold_cnt = 150;
        hold_done = 1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        result.ready <= 1'b0;
      end else if (rx_random) begin
        result.ready <= $urandom_range(0, 3) != 0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  // hang detection
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || cfg_we || (element.valid && element.ready) || (result.valid && result.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

// ===== elementwise_activation_unit.f =====
rtl/core/eau_pkg.sv
rtl/core/eau_if.sv
rtl/core/eau_div.sv
rtl/core/elementwise_activation_unit.sv
dv/elementwise_activation_unit_test.sv
